// File: src/tsfp_pkg.sv
`default_nettype none
package tsfp_pkg;

  localparam int MAX_CHANNELS = 64;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int CNT_W        = 7;
  localparam int BYTE_W       = 8;
  localparam int VAL_W        = 32;
  localparam int OUT_TDATA_W  = ((CH_W + VAL_W + 7) / 8) * 8;

  // configuration register indexes
  localparam logic REG_CHANNEL_COUNT = 1'b0;
  localparam logic REG_SEPARATOR     = 1'b1;

  localparam logic [CNT_W-1:0]  CHANNEL_COUNT_RST = 7'd1;
  localparam logic [BYTE_W-1:0] SEPARATOR_RST     = 8'd44;

  localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
  localparam logic [BYTE_W-1:0] CH_NL    = 8'd10;
  localparam logic [BYTE_W-1:0] CH_VT    = 8'd11;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'd12;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CH_NEL   = 8'd133;
  localparam logic [BYTE_W-1:0] CH_NBSP  = 8'd160;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'd35;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'd45;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'd57;

  localparam logic [VAL_W-1:0] MAG_CAP = 32'h8000_0000;
  localparam logic [VAL_W-1:0] POS_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic       is_nl;
    logic       is_last;
    logic       is_sep;
    logic       is_blank;
    logic       is_hash;
    logic       is_digit;
    logic       is_sign;
    logic       is_minus;
    logic [3:0] digit;
  } byte_class_t;

  typedef enum logic [2:0] {
    LINE_START   = 3'b001,
    LINE_DATA    = 3'b010,
    LINE_COMMENT = 3'b100
  } line_mode_t;

endpackage
`default_nettype wire

// File: src/tsfp_classify.sv
`default_nettype none
module tsfp_classify
  import tsfp_pkg::*;
(
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              stream_end,
  input  wire logic [BYTE_W-1:0] separator_byte,
  output byte_class_t            cls
);

  logic [BYTE_W-1:0] digit_off;

  assign digit_off = data_byte - CH_ZERO;

  always_comb begin
    cls          = '0;
    cls.is_nl    = (data_byte == CH_NL);
    cls.is_last  = stream_end;
    cls.is_sep   = (data_byte == separator_byte);
    cls.is_blank = data_byte inside {CH_TAB, CH_VT, CH_FF, CH_CR, CH_SPACE, CH_NEL, CH_NBSP};
    cls.is_hash  = (data_byte == CH_HASH);
    cls.is_digit = data_byte inside {[CH_ZERO:CH_NINE]};
    cls.is_sign  = (data_byte == CH_PLUS) || (data_byte == CH_MINUS);
    cls.is_minus = (data_byte == CH_MINUS);
    cls.digit    = digit_off[3:0];
  end

endmodule
`default_nettype wire

// File: src/tsfp_queue.sv
`default_nettype none
module tsfp_queue
  import tsfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  byte_class_t      push_data,
  output logic             full,
  input  wire logic        pop,
  output byte_class_t      pop_data,
  output logic             not_empty
);

  byte_class_t mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        do_push, do_pop;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: src/tsfp_exec.sv
`default_nettype none
module tsfp_exec
  import tsfp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CNT_W-1:0] channel_count,
  input  byte_class_t           cls,
  input  wire logic             cls_valid,
  output logic                  cls_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [CH_W-1:0]       out_channel,
  output logic [VAL_W-1:0]      out_value
);

  line_mode_t         line_r, line_nxt;
  logic               in_field_r, in_field_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [VAL_W-1:0]   acc_r, acc_nxt;
  logic               neg_r, neg_nxt;
  logic               open_r, open_nxt;
  logic               text_r, text_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]    out_ch_r, out_ch_nxt;
  logic [VAL_W-1:0]   out_val_r, out_val_nxt;

  logic               do_data, do_close, end_line, emit;
  logic [CNT_W-1:0]   limit;
  logic [VAL_W+3:0]   acc_x10;

  assign cls_pop     = cls_valid && (!out_valid_r || out_ready);
  assign out_valid   = out_valid_r;
  assign out_channel = out_ch_r;
  assign out_value   = out_val_r;

  assign limit   = (channel_count > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) : channel_count;
  assign acc_x10 = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {{VAL_W{1'b0}}, cls.digit};

  always_comb begin
    line_nxt      = line_r;
    in_field_nxt  = in_field_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    open_nxt      = open_r;
    text_nxt      = text_r;
    out_ch_nxt    = out_ch_r;
    out_val_nxt   = out_val_r;
    out_valid_nxt = out_valid_r;
    do_data       = 1'b0;
    do_close      = 1'b0;
    end_line      = 1'b0;
    emit          = 1'b0;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cls_pop) begin
      if (cls.is_nl) begin
        end_line = 1'b1;
      end else begin
        case (line_r)
          LINE_START: begin
            if (cls.is_blank) begin
              line_nxt = LINE_START;
            end else if (cls.is_hash) begin
              line_nxt = LINE_COMMENT;
            end else begin
              line_nxt = LINE_DATA;
              do_data  = 1'b1;
            end
          end
          LINE_DATA:    do_data = 1'b1;
          LINE_COMMENT: do_data = 1'b0;
          default:      do_data = 1'b0;
        endcase
        end_line = cls.is_last;
      end

      if (do_data && !cls.is_sep) begin
        in_field_nxt = 1'b1;
        if (!text_r) begin
          if (!cls.is_blank) begin
            text_nxt = 1'b1;
            if (cls.is_sign) begin
              neg_nxt  = cls.is_minus;
              open_nxt = 1'b1;
            end else if (cls.is_digit) begin
              acc_nxt  = {{(VAL_W-4){1'b0}}, cls.digit};
              open_nxt = 1'b1;
            end else begin
              open_nxt = 1'b0;
            end
          end
        end else if (open_r) begin
          if (cls.is_digit) begin
            acc_nxt = (acc_x10 > {4'b0, MAG_CAP}) ? MAG_CAP : acc_x10[VAL_W-1:0];
          end else begin
            open_nxt = 1'b0;
          end
        end
      end

      // a separator closed by the same byte leaves the field closed for end of line
      do_close = in_field_nxt && (end_line || (do_data && cls.is_sep));
      if (do_close) begin
        emit = text_nxt && (idx_r < limit);
        if (emit) begin
          out_ch_nxt  = idx_r[CH_W-1:0];
          out_val_nxt = neg_nxt ? (~acc_nxt + 1'b1)
                                : ((acc_nxt > POS_MAX) ? POS_MAX : acc_nxt);
        end
        if (idx_r != {CNT_W{1'b1}}) begin
          idx_nxt = idx_r + 1'b1;
        end
        in_field_nxt = 1'b0;
        acc_nxt      = '0;
        neg_nxt      = 1'b0;
        open_nxt     = 1'b0;
        text_nxt     = 1'b0;
      end
      if (end_line) begin
        line_nxt = LINE_START;
        idx_nxt  = '0;
      end
      out_valid_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r      <= LINE_START;
      in_field_r  <= 1'b0;
      idx_r       <= '0;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      open_r      <= 1'b0;
      text_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      line_r      <= line_nxt;
      in_field_r  <= in_field_nxt;
      idx_r       <= idx_nxt;
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      open_r      <= open_nxt;
      text_r      <= text_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ch_r  <= out_ch_nxt;
    out_val_r <= out_val_nxt;
  end

endmodule
`default_nettype wire

// File: src/text_sample_field_parser.sv
// Text sample field parser: turns a separated-integer text stream into samples.
// Input stream: one byte per transaction on in_tdata, in_tlast marks the final
//   byte of the stream (the line is ended right after it).
// Output stream: one transaction per field that holds text and whose position
//   in its line is below channel_count, capped at 64; carries the channel
//   index and the saturated signed 32-bit value.
// Configuration: cfg_we writes cfg_data into the register picked by cfg_index
//   (channel_count, separator_byte); write only while the block is idle.
// Throughput: one byte per cycle unless a sample waits on out_tready. The
//   front end classifies each byte into a two-entry queue; the back end updates
//   the line/field state and the times-ten accumulator once per popped byte.
// Path: each byte is held in the queue, then the back end pops it and loads
//   the sample into the output register that drives out_tvalid.
// Stalls: when out_tready is low the sample waits in the output register and
//   the queue takes up to two more bytes before in_tready drops.
// Reset (rst_n low, synchronous): queue and output emptied, parser at line
//   start, channel_count = 1, separator_byte = ','.
`default_nettype none
module text_sample_field_parser
  import tsfp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [BYTE_W-1:0]      in_tdata,   // [7:0] data_byte
  input  wire logic                   in_tlast,   // stream_end
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [5:0] channel_index, [37:6] sample_value
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [BYTE_W-1:0]      cfg_data
);

  logic [CNT_W-1:0]  chan_cnt_r;
  logic [BYTE_W-1:0] sep_r;
  byte_class_t       in_cls, q_cls;
  logic              q_full, q_valid, q_pop;
  logic [CH_W-1:0]   res_ch;
  logic [VAL_W-1:0]  res_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= CHANNEL_COUNT_RST;
      sep_r      <= SEPARATOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: chan_cnt_r <= cfg_data[CNT_W-1:0];
        REG_SEPARATOR:     sep_r      <= cfg_data;
        default:           sep_r      <= sep_r;
      endcase
    end
  end

  tsfp_classify u_classify (
    .data_byte      (in_tdata),
    .stream_end     (in_tlast),
    .separator_byte (sep_r),
    .cls            (in_cls)
  );

  assign in_tready = !q_full;

  tsfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_data (in_cls),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_cls),
    .not_empty (q_valid)
  );

  tsfp_exec u_exec (
    .clk           (clk),
    .rst_n         (rst_n),
    .channel_count (chan_cnt_r),
    .cls           (q_cls),
    .cls_valid     (q_valid),
    .cls_pop       (q_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_channel   (res_ch),
    .out_value     (res_val)
  );

  assign out_tdata = {{(OUT_TDATA_W-CH_W-VAL_W){1'b0}}, res_val, res_ch};

endmodule
`default_nettype wire
